FILE: rtl/core/wss_pkg.sv
// Shared constants and types for the windowed sample statistics core.
package wss_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int TIME_W         = 32;
	localparam int CNT_W          = 32;
	localparam int SUM_W          = 64;
	localparam int OUT_W          = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [TIME_W-1:0] START_TIME_RST    = 32'd0;
	localparam logic [TIME_W-1:0] END_TIME_RST      = 32'hFFFF_FFFF;
	localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 32'd3600;

	// One closed window (or a drop marker) handed from front to back.
	typedef struct packed {
		logic                    dropped;
		logic [TIME_W-1:0]       win_start;
		logic [CNT_W-1:0]        count;
		logic signed [SUM_W-1:0] sum;
		logic [OUT_W-1:0]        min_val;
		logic [OUT_W-1:0]        max_val;
	} win_t;

endpackage

FILE: rtl/core/windowed_sample_statistics_core.sv
// Top level of the windowed sample statistics core: register port, front, queue, back.
//
//   channel   direction  handshake         word
//   --------  ---------  ----------------  -------------------------------------------
//   input     in         push / full       kind, sample_time, sample_value
//   result    out        empty / pop       window_begin, sample_count, mean_value,
//                                          min_value, max_value, dropped
//   config    in/out     psel/penable/...  start_time @0x0, end_time @0x4, length @0x8
//
// A plain sample is captured, then accumulated; one that closes a window holds the
// front while the 32-bit divider finds offset mod length; the new start is t minus that.
// The back runs each emitted window through the 64/32 mean divider (drop words skip it)
// and takes no new word before the last is in the output register. full is high while
// the front holds a word, also while a word waits for room in the two-word queue to the back.
// Reset is asynchronous and clears all control and accumulator state at once; no clearing pass.
module windowed_sample_statistics_core #(
	parameter int VALUE_BITS = wss_pkg::VALUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input word
	input  logic                       push,
	output logic                       full,
	input  logic                       kind,
	input  logic [wss_pkg::TIME_W-1:0] sample_time,
	input  logic signed [31:0]         sample_value,
	// result word
	output logic                       empty,
	input  logic                       pop,
	output logic [wss_pkg::TIME_W-1:0] window_begin,
	output logic [wss_pkg::CNT_W-1:0]  sample_count,
	output logic signed [31:0]         mean_value,
	output logic signed [31:0]         min_value,
	output logic signed [31:0]         max_value,
	output logic                       dropped,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam logic [1:0] REG_START_TIME    = 2'd0;
	localparam logic [1:0] REG_END_TIME      = 2'd1;
	localparam logic [1:0] REG_WINDOW_LENGTH = 2'd2;

	logic [wss_pkg::TIME_W-1:0] start_time_q;
	logic [wss_pkg::TIME_W-1:0] end_time_q;
	logic [wss_pkg::TIME_W-1:0] window_length_q;

	logic [1:0]    reg_idx;
	logic          reg_wr;

	logic          enq_valid;
	wss_pkg::win_t enq_word;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	wss_pkg::win_t q_word;

	// Register port: zero wait states, word index from paddr[3:2].
	// start_time is picked up by the front only at flush or reset;
	// end_time and window_length act on the open window at once.
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= wss_pkg::START_TIME_RST;
			end_time_q      <= wss_pkg::END_TIME_RST;
			window_length_q <= wss_pkg::WINDOW_LENGTH_RST;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_START_TIME:    start_time_q    <= pwdata;
				REG_END_TIME:      end_time_q      <= pwdata;
				REG_WINDOW_LENGTH: window_length_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_START_TIME:    prdata = start_time_q;
			REG_END_TIME:      prdata = end_time_q;
			REG_WINDOW_LENGTH: prdata = window_length_q;
			default:           prdata = '0;
		endcase
	end

	// Front: classifies each word (flush, drop, in window, closing) and
	// owns the open window start and the count/sum/min/max accumulators.
	wss_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.kind          (kind),
		.sample_time   (sample_time),
		.sample_value  (sample_value),
		.start_time    (start_time_q),
		.end_time      (end_time_q),
		.window_length (window_length_q),
		.enq_valid     (enq_valid),
		.enq_word      (enq_word),
		.q_full        (q_full)
	);

	// Closed windows and drop markers wait here for the mean divider.
	wss_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (enq_valid),
		.wr_word (enq_word),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_word (q_word),
		.empty   (q_empty)
	);

	// Back: mean = |sum| / count with the sign put back (truncates toward
	// zero), then the result word sits in the output register until popped.
	wss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_word       (q_word),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.window_begin (window_begin),
		.sample_count (sample_count),
		.mean_value   (mean_value),
		.min_value    (min_value),
		.max_value    (max_value),
		.dropped      (dropped)
	);

endmodule

FILE: rtl/core/wss_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module wss_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   part;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		part = {rem_q, quo_q[NUM_W-1]};
		diff = part - {1'b0, den_q};
		ge   = part >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/wss_fifo.sv
// Short word queue between the front and back parts.
module wss_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  wss_pkg::win_t wr_word,
	output logic          full,
	input  logic          rd_en,
	output wss_pkg::win_t rd_word,
	output logic          empty
);

	localparam int DEPTH = wss_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	wss_pkg::win_t mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [NW-1:0] fill_q;

	logic do_wr;
	logic do_rd;

	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign full  = fill_q == NW'(DEPTH);
	assign empty = fill_q == '0;
	assign rd_word = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_word;
		end
	end

endmodule

FILE: rtl/core/wss_front.sv
// Front part: takes input words, tracks the open window and its accumulators.
module wss_front #(
	parameter int VALUE_BITS = wss_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          kind,
	input  logic [wss_pkg::TIME_W-1:0]    sample_time,
	input  logic signed [31:0]            sample_value,
	input  logic [wss_pkg::TIME_W-1:0]    start_time,
	input  logic [wss_pkg::TIME_W-1:0]    end_time,
	input  logic [wss_pkg::TIME_W-1:0]    window_length,
	output logic                          enq_valid,
	output wss_pkg::win_t                 enq_word,
	input  logic                          q_full
);

	localparam int VB    = VALUE_BITS;
	localparam int TW    = wss_pkg::TIME_W;
	localparam int CW    = wss_pkg::CNT_W;
	localparam int SW    = wss_pkg::SUM_W;
	localparam int OW    = wss_pkg::OUT_W;
	localparam int EXT_W = (VB > 32) ? VB : 32;

	localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [CW-1:0]        CNT_SAT = '1;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_EVAL = 2'd1;
	localparam logic [1:0] F_DIV  = 2'd2;

	logic [1:0]            state_q;
	logic                  kind_q;
	logic [TW-1:0]         time_q;
	logic [31:0]           val_q;
	logic [TW-1:0]         open_q;
	logic [CW-1:0]         cnt_q;
	logic signed [SW-1:0]  sum_q;
	logic signed [VB-1:0]  min_q;
	logic signed [VB-1:0]  max_q;

	logic [EXT_W-1:0]      raw;
	logic signed [VB-1:0]  v;
	logic signed [SW-1:0]  v_sum;
	logic [TW-1:0]         len_eff;
	logic                  is_drop;
	logic [TW-1:0]         off;
	logic                  in_win;
	logic [SW:0]           sum_x;
	logic signed [SW-1:0]  sum_sat;
	logic [SW-1:0]         min_ext;
	logic [SW-1:0]         max_ext;
	logic                  has_samples;
	logic                  eval_go;
	logic                  need_enq;
	logic                  div_start;
	logic                  div_done;
	logic [TW-1:0]         div_rem;

	always_comb begin
		raw     = EXT_W'(val_q);
		v       = raw[VB-1:0];
		v_sum   = {{(SW-VB){v[VB-1]}}, v};
		len_eff = (window_length == '0) ? TW'(1) : window_length;
		is_drop = (time_q >= end_time) || (time_q < open_q);
		off     = time_q - open_q;
		in_win  = off < len_eff;
		sum_x   = {sum_q[SW-1], sum_q} + {v_sum[SW-1], v_sum};
		if (sum_x[SW] != sum_x[SW-1]) begin
			sum_sat = sum_x[SW] ? SMIN : SMAX;
		end else begin
			sum_sat = sum_x[SW-1:0];
		end
		min_ext     = {{(SW-VB){min_q[VB-1]}}, min_q};
		max_ext     = {{(SW-VB){max_q[VB-1]}}, max_q};
		has_samples = cnt_q != '0;
	end

	// what the item in hand needs this cycle
	always_comb begin
		eval_go  = 1'b0;
		need_enq = 1'b0;
		if (kind_q) begin
			need_enq = has_samples;
			eval_go  = !has_samples || !q_full;
		end else if (is_drop) begin
			need_enq = 1'b1;
			eval_go  = !q_full;
		end else if (in_win) begin
			eval_go  = 1'b1;
		end else begin
			need_enq = has_samples;
			eval_go  = !has_samples || !q_full;
		end
	end

	always_comb begin
		enq_word = '0;
		if (!kind_q && is_drop) begin
			enq_word.dropped = 1'b1;
		end else begin
			enq_word.win_start = open_q;
			enq_word.count     = cnt_q;
			enq_word.sum       = sum_q;
			enq_word.min_val   = min_ext[OW-1:0];
			enq_word.max_val   = max_ext[OW-1:0];
		end
		enq_valid = (state_q == F_EVAL) && eval_go && need_enq;
		div_start = (state_q == F_EVAL) && eval_go && !kind_q && !is_drop && !in_win;
	end

	assign full = state_q != F_IDLE;

	wss_div #(
		.NUM_W (TW),
		.DEN_W (TW)
	) u_win_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (off),
		.den    (len_eff),
		.done   (div_done),
		.quot   (),
		.rem    (div_rem)
	);

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			kind_q <= kind;
			time_q <= sample_time;
			val_q  <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			open_q  <= wss_pkg::START_TIME_RST;
			cnt_q   <= '0;
			sum_q   <= '0;
			min_q   <= VMAX;
			max_q   <= VMIN;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (push) begin
						state_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					if (eval_go) begin
						if (kind_q) begin
							open_q  <= start_time;
							cnt_q   <= '0;
							sum_q   <= '0;
							min_q   <= VMAX;
							max_q   <= VMIN;
							state_q <= F_IDLE;
						end else if (is_drop) begin
							state_q <= F_IDLE;
						end else if (in_win) begin
							if (cnt_q != CNT_SAT) begin
								cnt_q <= cnt_q + CW'(1);
								sum_q <= sum_sat;
							end
							if (v < min_q) begin
								min_q <= v;
							end
							if (v > max_q) begin
								max_q <= v;
							end
							state_q <= F_IDLE;
						end else begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					// new start = t - (off mod len); fresh window holds this sample
					if (div_done) begin
						open_q  <= time_q - div_rem;
						cnt_q   <= CW'(1);
						sum_q   <= v_sum;
						min_q   <= v;
						max_q   <= v;
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/wss_back.sv
// Back part: divides sum by count for the mean and holds the output word.
module wss_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  wss_pkg::win_t              q_word,
	output logic                       q_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [wss_pkg::TIME_W-1:0] window_begin,
	output logic [wss_pkg::CNT_W-1:0]  sample_count,
	output logic signed [31:0]         mean_value,
	output logic signed [31:0]         min_value,
	output logic signed [31:0]         max_value,
	output logic                       dropped
);

	localparam int SW = wss_pkg::SUM_W;
	localparam int OW = wss_pkg::OUT_W;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_PUT  = 2'd2;

	logic [1:0]    state_q;
	logic          ovalid_q;
	wss_pkg::win_t work_q;
	logic          neg_q;

	logic          head_neg;
	logic [SW-1:0] head_mag;
	logic          div_start;
	logic          div_done;
	logic [SW-1:0] div_quot;
	logic [OW-1:0] q_low;
	logic [OW-1:0] mean_nxt;
	logic          out_free;

	always_comb begin
		head_neg  = q_word.sum[SW-1];
		head_mag  = head_neg ? (~q_word.sum + SW'(1)) : q_word.sum;
		q_pop     = (state_q == B_IDLE) && !q_empty;
		div_start = q_pop && !q_word.dropped;
		q_low     = div_quot[OW-1:0];
		if (work_q.dropped) begin
			mean_nxt = '0;
		end else begin
			mean_nxt = neg_q ? (~q_low + OW'(1)) : q_low;
		end
		out_free  = !ovalid_q || pop;
	end

	wss_div #(
		.NUM_W (SW),
		.DEN_W (wss_pkg::CNT_W)
	) u_mean_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (head_mag),
		.den    (q_word.count),
		.done   (div_done),
		.quot   (div_quot),
		.rem    ()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == B_PUT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= q_word.dropped ? B_PUT : B_DIV;
					end
				end
				B_DIV: begin
					if (div_done) begin
						state_q <= B_PUT;
					end
				end
				B_PUT: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_word;
			neg_q  <= head_neg;
		end
		if (state_q == B_PUT && out_free) begin
			window_begin <= work_q.win_start;
			sample_count <= work_q.count;
			mean_value   <= mean_nxt;
			min_value    <= work_q.min_val;
			max_value    <= work_q.max_val;
			dropped      <= work_q.dropped;
		end
	end

	assign empty = !ovalid_q;

endmodule
